FILE: rtl/fpa_pkg.sv
// Shared types, codes and helper functions of the binary32 arithmetic pipeline.
package fpa_pkg;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
	localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
	localparam int          DIV_STEPS    = 27;
	// unpack, align, add/multiply, leading-zero count, normalize, divide steps, round (2)
	localparam int          LATENCY      = 5 + DIV_STEPS + 2;

	// classified operand; mant has its leading one at bit 23 for finite nonzero values
	typedef struct packed {
		logic               nan;
		logic               inf;
		logic               zero;
		logic               sign;
		logic signed [10:0] exp;
		logic [23:0]        mant;
	} opnd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic               last;
		logic               spec;
		logic [31:0]        spec_val;
		logic               sign;
		logic               sub;
		logic signed [10:0] ea;
		logic signed [10:0] eb;
		logic [23:0]        ma;
		logic [23:0]        mb;
	} front_t;

	typedef struct packed {
		cmd_t               cmd;
		logic               last;
		logic               spec;
		logic [31:0]        spec_val;
		logic               sign;
		logic               sub;
		logic signed [10:0] e;
		logic [23:0]        ma;
		logic [23:0]        mb;
		logic [47:0]        p;
		logic [55:0]        y;
	} align_t;

	typedef struct packed {
		cmd_t               cmd;
		logic               last;
		logic               spec;
		logic [31:0]        spec_val;
		logic               sign;
		logic               sub;
		logic signed [10:0] e;
		logic [56:0]        x;
		logic [5:0]         lz;
		logic [26:0]        m;
		logic [23:0]        ma;
		logic [23:0]        mb;
	} sum_t;

	// m has its leading one at bit 26, bit 0 sticky; r is the divider's partial remainder
	typedef struct packed {
		cmd_t               cmd;
		logic               last;
		logic               spec;
		logic [31:0]        spec_val;
		logic               sign;
		logic signed [10:0] e;
		logic [26:0]        m;
		logic [24:0]        r;
		logic [23:0]        mb;
	} chain_t;

	function automatic logic [5:0] lzc56(input logic [55:0] x);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < 56; i++) begin
			if (x[i]) begin
				n = 6'(55 - i);
			end
		end
		return n;
	endfunction

	function automatic logic [4:0] lzc24(input logic [23:0] x);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 24; i++) begin
			if (x[i]) begin
				n = 5'(23 - i);
			end
		end
		return n;
	endfunction

endpackage

FILE: rtl/fpa_unpack.sv
// Operand classifier: special-value detection and subnormal normalization.
module fpa_unpack (
	input  logic [31:0]   operand,
	output fpa_pkg::opnd_t info
);

	logic [23:0] f24;
	logic [4:0]  lz;
	logic        exp_zero;

	assign f24      = {1'b0, operand[22:0]};
	assign lz       = fpa_pkg::lzc24(f24);
	assign exp_zero = (operand[30:23] == 8'd0);

	always_comb begin
		info.nan  = (operand[30:23] == 8'hFF) && (operand[22:0] != 23'd0);
		info.inf  = (operand[30:23] == 8'hFF) && (operand[22:0] == 23'd0);
		info.zero = (operand[30:0] == 31'd0);
		info.sign = operand[31];
		if (exp_zero) begin
			// subnormal: move the leading one up to bit 23
			info.mant = f24 << lz;
			info.exp  = 11'sd1 - $signed({6'd0, lz});
		end else begin
			info.mant = {1'b1, operand[22:0]};
			info.exp  = $signed({3'd0, operand[30:23]});
		end
	end

endmodule

FILE: rtl/fpa_round.sv
// Two-stage denormalize, round-to-nearest-even and pack of the pipeline result.
module fpa_round (
	input  logic            clk,
	input  logic            adv,
	input  fpa_pkg::chain_t in,
	output logic [31:0]     result_value,
	output logic            result_last
);

	typedef struct packed {
		logic        last;
		logic        spec;
		logic [31:0] spec_val;
		logic        sign;
		logic        ovf;
		logic [7:0]  e;
		logic [26:0] m;
	} rnd_t;

	rnd_t               nx_s1;
	rnd_t               rnd_s1;
	logic [26:0]        m0;
	logic signed [10:0] sh;
	logic [23:0]        sig;
	logic               inc;
	logic [24:0]        sig_r;
	logic [30:0]        mag;

	// fold the remainder into the sticky bit, then shift subnormal results right
	always_comb begin
		m0 = in.m;
		if (in.cmd == fpa_pkg::CMD_DIV && in.r != 25'd0) begin
			m0[0] = 1'b1;
		end
		sh             = 11'sd1 - in.e;
		nx_s1.last     = in.last;
		nx_s1.spec     = in.spec;
		nx_s1.spec_val = in.spec_val;
		nx_s1.sign     = in.sign;
		nx_s1.ovf      = (in.e >= 11'sd255);
		if (in.e <= 11'sd0) begin
			nx_s1.e = 8'd1;
			if (sh >= 11'sd32) begin
				nx_s1.m = {26'd0, |m0};
			end else begin
				nx_s1.m = (m0 >> sh[4:0])
					| {26'd0, |(m0 & ~(27'h7FF_FFFF << sh[4:0]))};
			end
		end else begin
			nx_s1.e = in.e[7:0];
			nx_s1.m = m0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rnd_s1 <= nx_s1;
		end
	end

	// a carry out of the significand rolls into the exponent field on its own
	always_comb begin
		sig   = rnd_s1.m[26:3];
		inc   = (rnd_s1.m[2:0] > 3'd4) || (rnd_s1.m[2:0] == 3'd4 && sig[0]);
		sig_r = {1'b0, sig} + {24'd0, inc};
		mag   = {rnd_s1.e - 8'd1, 23'd0} + {6'd0, sig_r};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_last <= rnd_s1.last;
			if (rnd_s1.spec) begin
				result_value <= rnd_s1.spec_val;
			end else if (rnd_s1.ovf) begin
				result_value <= {rnd_s1.sign, 8'hFF, 23'd0};
			end else begin
				result_value <= {rnd_s1.sign, mag};
			end
		end
	end

endmodule

FILE: rtl/fp32_elementwise_arith.sv
// Element-wise binary32 add / subtract / multiply / divide pipeline, top level.
// Structure: 5 front stages, 27 restoring-division steps of one quotient bit
//   each, 2 rounding stages.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Reset: arst_n clears only the stage valid bits; payload registers are not reset.
module fp32_elementwise_arith (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	input  logic        last_element,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_value,
	output logic        result_last
);

	// One enable for every stage: advance unless the finished item is held.
	logic adv;
	logic [fpa_pkg::LATENCY-1:0] vld_q;

	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[fpa_pkg::LATENCY-1];

	// Valid bits shift along with the data; bubbles travel as invalid slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[fpa_pkg::LATENCY-2:0], in_valid};
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Classify both operands, settle every special operand case (NaN, infinity, zero,
	// invalid operation) right here, and for add/subtract put the larger
	// magnitude first so the aligner only ever shifts the second operand.
	fpa_pkg::opnd_t ua;
	fpa_pkg::opnd_t ub;
	fpa_pkg::front_t nx_s1;
	fpa_pkg::front_t front_s1;
	fpa_pkg::cmd_t cmd_in;
	logic sbe;
	logic swap;
	logic [31:0] b_eff;

	fpa_unpack u_unpack_a (.operand(operand_a), .info(ua));
	fpa_unpack u_unpack_b (.operand(operand_b), .info(ub));

	assign cmd_in = fpa_pkg::cmd_t'(command);

	always_comb begin
		// subtract is add with the second sign flipped
		sbe   = ub.sign ^ (cmd_in == fpa_pkg::CMD_SUB);
		b_eff = {sbe, operand_b[30:0]};
		swap  = (operand_a[30:0] < operand_b[30:0]);

		nx_s1.cmd      = cmd_in;
		nx_s1.last     = last_element;
		nx_s1.spec     = 1'b1;
		nx_s1.spec_val = '0;
		nx_s1.sign     = ua.sign ^ ub.sign;
		nx_s1.sub      = (ua.sign != sbe);
		nx_s1.ea       = ua.exp;
		nx_s1.eb       = ub.exp;
		nx_s1.ma       = ua.mant;
		nx_s1.mb       = ub.mant;

		if (ua.nan) begin
			nx_s1.spec_val = operand_a | fpa_pkg::QUIET_BIT;
		end else if (ub.nan) begin
			nx_s1.spec_val = operand_b | fpa_pkg::QUIET_BIT;
		end else begin
			case (cmd_in)
				fpa_pkg::CMD_ADD, fpa_pkg::CMD_SUB: begin
					if (ua.inf) begin
						nx_s1.spec_val = (ub.inf && ua.sign != sbe) ?
							fpa_pkg::QNAN_DEFAULT : operand_a;
					end else if (ub.inf) begin
						nx_s1.spec_val = b_eff;
					end else if (ua.zero && ub.zero) begin
						nx_s1.spec_val = {ua.sign & sbe, 31'd0};
					end else if (ua.zero) begin
						nx_s1.spec_val = b_eff;
					end else if (ub.zero) begin
						nx_s1.spec_val = operand_a;
					end else begin
						nx_s1.spec = 1'b0;
					end
					if (swap) begin
						nx_s1.sign = sbe;
						nx_s1.ea   = ub.exp;
						nx_s1.eb   = ua.exp;
						nx_s1.ma   = ub.mant;
						nx_s1.mb   = ua.mant;
					end else begin
						nx_s1.sign = ua.sign;
					end
				end
				fpa_pkg::CMD_MUL: begin
					if (ua.inf || ub.inf) begin
						nx_s1.spec_val = (ua.zero || ub.zero) ? fpa_pkg::QNAN_DEFAULT :
							{ua.sign ^ ub.sign, 8'hFF, 23'd0};
					end else if (ua.zero || ub.zero) begin
						nx_s1.spec_val = {ua.sign ^ ub.sign, 31'd0};
					end else begin
						nx_s1.spec = 1'b0;
					end
				end
				fpa_pkg::CMD_DIV: begin
					if (ua.inf) begin
						nx_s1.spec_val = ub.inf ? fpa_pkg::QNAN_DEFAULT :
							{ua.sign ^ ub.sign, 8'hFF, 23'd0};
					end else if (ub.inf) begin
						nx_s1.spec_val = {ua.sign ^ ub.sign, 31'd0};
					end else if (ub.zero) begin
						nx_s1.spec_val = ua.zero ? fpa_pkg::QNAN_DEFAULT :
							{ua.sign ^ ub.sign, 8'hFF, 23'd0};
					end else if (ua.zero) begin
						nx_s1.spec_val = {ua.sign ^ ub.sign, 31'd0};
					end else begin
						nx_s1.spec = 1'b0;
					end
				end
				default: begin
					nx_s1.spec = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			front_s1 <= nx_s1;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Align the smaller addend (right shift with sticky), form the raw
	// 24x24 product, and work out the result exponent for mul/div.
	fpa_pkg::align_t nx_s2;
	fpa_pkg::align_t align_s2;
	logic signed [10:0] d;
	logic [55:0] y0;

	always_comb begin
		d  = front_s1.ea - front_s1.eb;
		y0 = {front_s1.mb, 32'd0};

		nx_s2.cmd      = front_s1.cmd;
		nx_s2.last     = front_s1.last;
		nx_s2.spec     = front_s1.spec;
		nx_s2.spec_val = front_s1.spec_val;
		nx_s2.sign     = front_s1.sign;
		nx_s2.sub      = front_s1.sub;
		nx_s2.ma       = front_s1.ma;
		nx_s2.mb       = front_s1.mb;
		nx_s2.p        = front_s1.ma * front_s1.mb;

		if (d >= 11'sd56) begin
			nx_s2.y = 56'd1;
		end else begin
			nx_s2.y = (y0 >> d[5:0]) | {55'd0, |(y0 & ~({56{1'b1}} << d[5:0]))};
		end

		case (front_s1.cmd)
			fpa_pkg::CMD_MUL: nx_s2.e = front_s1.ea + front_s1.eb - 11'sd127;
			fpa_pkg::CMD_DIV: begin
				if (front_s1.ma >= front_s1.mb) begin
					nx_s2.e = front_s1.ea - front_s1.eb + 11'sd127;
				end else begin
					nx_s2.e = front_s1.ea - front_s1.eb + 11'sd126;
				end
			end
			default: nx_s2.e = front_s1.ea;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			align_s2 <= nx_s2;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// Wide add or subtract; normalize the product to the 27-bit form.
	fpa_pkg::sum_t nx_s3;
	fpa_pkg::sum_t sum_s3;
	logic [56:0] xa;

	always_comb begin
		xa = {1'b0, align_s2.ma, 32'd0};

		nx_s3.cmd      = align_s2.cmd;
		nx_s3.last     = align_s2.last;
		nx_s3.spec     = align_s2.spec;
		nx_s3.spec_val = align_s2.spec_val;
		nx_s3.sign     = align_s2.sign;
		nx_s3.sub      = align_s2.sub;
		nx_s3.ma       = align_s2.ma;
		nx_s3.mb       = align_s2.mb;
		nx_s3.lz       = '0;
		nx_s3.x        = align_s2.sub ? (xa - {1'b0, align_s2.y}) : (xa + {1'b0, align_s2.y});

		if (align_s2.p[47]) begin
			nx_s3.m = align_s2.p[47:21] | {26'd0, |align_s2.p[20:0]};
		end else begin
			nx_s3.m = align_s2.p[46:20] | {26'd0, |align_s2.p[19:0]};
		end
		if (align_s2.cmd == fpa_pkg::CMD_MUL && align_s2.p[47]) begin
			nx_s3.e = align_s2.e + 11'sd1;
		end else begin
			nx_s3.e = align_s2.e;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= nx_s3;
		end
	end

	// ---------------------------------------------------------------- stage 4
	// Fold a carry-out of the sum back in; detect exact cancellation (+0)
	// and count leading zeros of a difference.
	fpa_pkg::sum_t nx_s4;
	fpa_pkg::sum_t sum_s4;
	logic is_addsub3;

	always_comb begin
		is_addsub3 = (sum_s3.cmd == fpa_pkg::CMD_ADD) || (sum_s3.cmd == fpa_pkg::CMD_SUB);
		nx_s4      = sum_s3;
		nx_s4.lz   = sum_s3.sub ? fpa_pkg::lzc56(sum_s3.x[55:0]) : 6'd0;
		if (is_addsub3 && !sum_s3.spec) begin
			if (!sum_s3.sub && sum_s3.x[56]) begin
				nx_s4.x = {1'b0, sum_s3.x[56:2], sum_s3.x[1] | sum_s3.x[0]};
				nx_s4.e = sum_s3.e + 11'sd1;
			end else if (sum_s3.sub && sum_s3.x == 57'd0) begin
				nx_s4.spec     = 1'b1;
				nx_s4.spec_val = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4 <= nx_s4;
		end
	end

	// ---------------------------------------------------------------- stage 5
	// Shift the sum up to bit 55 and compress it to 27 bits; seed the
	// divider's partial remainder (dividend pre-doubled when ma < mb).
	fpa_pkg::chain_t nx_s5;
	fpa_pkg::chain_t chain_s5;
	logic [55:0] xs;
	logic is_addsub4;

	always_comb begin
		is_addsub4 = (sum_s4.cmd == fpa_pkg::CMD_ADD) || (sum_s4.cmd == fpa_pkg::CMD_SUB);
		xs         = sum_s4.x[55:0] << sum_s4.lz;

		nx_s5.cmd      = sum_s4.cmd;
		nx_s5.last     = sum_s4.last;
		nx_s5.spec     = sum_s4.spec;
		nx_s5.spec_val = sum_s4.spec_val;
		nx_s5.sign     = sum_s4.sign;
		nx_s5.mb       = sum_s4.mb;
		nx_s5.r        = (sum_s4.ma >= sum_s4.mb) ? {1'b0, sum_s4.ma} : {sum_s4.ma, 1'b0};

		if (is_addsub4) begin
			nx_s5.m = xs[55:29] | {26'd0, |xs[28:0]};
			nx_s5.e = sum_s4.e - $signed({5'd0, sum_s4.lz});
		end else if (sum_s4.cmd == fpa_pkg::CMD_DIV) begin
			nx_s5.m = '0;
			nx_s5.e = sum_s4.e;
		end else begin
			nx_s5.m = sum_s4.m;
			nx_s5.e = sum_s4.e;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chain_s5 <= nx_s5;
		end
	end

	// ------------------------------------------------------- division steps
	// Restoring division, one quotient bit per stage, MSB first. Other
	// operations ride along untouched so every item sees the same latency.
	fpa_pkg::chain_t div_s [fpa_pkg::DIV_STEPS];
	fpa_pkg::chain_t div_nx [fpa_pkg::DIV_STEPS];

	always_comb begin
		fpa_pkg::chain_t cur;
		logic            ge;
		logic [24:0]     rem;
		for (int k = 0; k < fpa_pkg::DIV_STEPS; k++) begin
			cur = (k == 0) ? chain_s5 : div_s[(k == 0) ? 0 : k - 1];
			ge  = (cur.r >= {1'b0, cur.mb});
			rem = ge ? (cur.r - {1'b0, cur.mb}) : cur.r;
			div_nx[k] = cur;
			if (cur.cmd == fpa_pkg::CMD_DIV) begin
				div_nx[k].m = {cur.m[25:0], ge};
				div_nx[k].r = {rem[23:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < fpa_pkg::DIV_STEPS; k++) begin
				div_s[k] <= div_nx[k];
			end
		end
	end

	// ------------------------------------------------------------- rounding
	// Two more stages; the second one is the output register.
	fpa_round u_round (
		.clk          (clk),
		.adv          (adv),
		.in           (div_s[fpa_pkg::DIV_STEPS-1]),
		.result_value (result_value),
		.result_last  (result_last)
	);

endmodule
